>>> sv/mbf_pkg.sv
// shared constants and types for the box mean filter
`timescale 1ns / 1ps
`default_nettype none
package mbf_pkg;

   localparam int PIXEL_W    = 8;
   localparam int CMD_W      = 1;
   localparam int RADIUS_W   = 2;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 12;
   localparam int ROW_W      = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int QUOT_W     = 8;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 2'd1;
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

   localparam logic [CMD_W-1:0] CMD_PIXEL = 1'b0;
   localparam logic [CMD_W-1:0] CMD_FLUSH = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

endpackage
`default_nettype wire

>>> sv/mbf_if.sv
// item channels of the box mean filter
`timescale 1ns / 1ps
`default_nettype none
interface mbf_req_if;
   logic                         valid;
   logic                         ready;
   logic [mbf_pkg::CMD_W-1:0]    cmd;
   logic [mbf_pkg::PIXEL_W-1:0]  pixel;
   modport source (output valid, cmd, pixel, input ready);
   modport sink (input valid, cmd, pixel, output ready);
endinterface

interface mbf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mbf_pkg::PIXEL_W-1:0]  mean_value;
   logic                         frame_last;
   modport source (output valid, mean_value, frame_last, input ready);
   modport sink (input valid, mean_value, frame_last, output ready);
endinterface
`default_nettype wire

>>> sv/mbf_ram.sv
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module mbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

>>> sv/mbf_cell.sv
// one row cell: picks its row's samples off the chain and forms a running prefix sum
`timescale 1ns / 1ps
`default_nettype none
module mbf_cell #(
   parameter int SAMPLE_W = 8,
   parameter int TAG_W    = 3,
   parameter int ACC_W    = 11,
   parameter int SUM_W    = 14
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                clear,
   input  wire logic                in_valid,
   input  wire logic [TAG_W-1:0]    in_tag,
   input  wire logic [SAMPLE_W-1:0] in_sample,
   input  wire logic [SUM_W-1:0]    in_pass,
   output logic                     out_valid,
   output logic      [TAG_W-1:0]    out_tag,
   output logic      [SAMPLE_W-1:0] out_sample,
   output logic      [SUM_W-1:0]    out_pass
);
   logic                valid_ff, valid_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [SUM_W-1:0]    pass_ff, pass_in;
   logic                mine;

   // tag counts down the cells still to go, zero means this row
   assign mine = in_valid && (in_tag == '0);

   always_comb begin
      valid_in = in_valid && !mine;
      tag_in   = in_tag - 1'b1;
      if (clear) begin
         acc_in = '0;
      end else if (mine) begin
         acc_in = acc_ff + ACC_W'(in_sample);
      end else begin
         acc_in = acc_ff;
      end
      pass_in = in_pass + SUM_W'(acc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         acc_ff   <= '0;
         pass_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         acc_ff   <= acc_in;
         pass_ff  <= pass_in;
      end
      tag_ff    <= tag_in;
      sample_ff <= in_sample;
   end

   assign out_valid  = valid_ff;
   assign out_tag    = tag_ff;
   assign out_sample = sample_ff;
   assign out_pass   = pass_ff;
endmodule
`default_nettype wire

>>> sv/box_mean_filter_unit.sv
// box mean filter top level: line store, window sequencer, row cell chain, divider
// items that produce no result (before the lag of r rows plus r pixels) leave the sequencer idle
// items with a result go through (2r+1)^2 store reads in the scan, the chain drain,
//   8 divide steps and delivery; the single read port of the line store sets the scan
// a finished result waits in the output register while the next item is taken
// reset is synchronous active high; control clears, the line store is not cleared;
//   input ready stays low after reset or a register write until the derived settings settle
`timescale 1ns / 1ps
`default_nettype none
module box_mean_filter_unit #(
   parameter int MAX_RADIUS = 3,
   parameter int MAX_WIDTH  = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   mbf_req_if.sink                              req_ch,
   mbf_rsp_if.source                            rsp_ch,
   input  wire logic                            csr_we,
   input  wire logic [mbf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mbf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   localparam int NC        = 2 * MAX_RADIUS + 1;
   localparam int TAG_W     = $clog2(NC);
   localparam int DEPTH     = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
   localparam int PTR_W     = $clog2(DEPTH);
   localparam int WW        = $clog2(MAX_WIDTH + 1);
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int CO_W      = $clog2(MAX_WIDTH + 2 * MAX_RADIUS + 1);
   localparam int RW        = $clog2(MAX_RADIUS + 1);
   localparam int LAG_W     = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
   localparam int ACC_W     = $clog2(NC * 255 + 1);
   localparam int SUM_W     = $clog2(NC * NC * 255 + 1);
   localparam int AREA_W    = $clog2(NC * NC + 1);
   localparam int DRAIN_CYC = 2 * NC + 4;
   localparam int CNT_W     = $clog2(DRAIN_CYC + 1);
   localparam int PW        = mbf_pkg::PIXEL_W;
   localparam int HW        = mbf_pkg::HEIGHT_W;
   localparam int QW        = mbf_pkg::QUOT_W;
   // cycles for the derived settings to follow a register write
   localparam logic [1:0] CFG_SETTLE = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SCAN    = 5'b00010,
      ST_DRAIN   = 5'b00100,
      ST_DIVIDE  = 5'b01000,
      ST_DELIVER = 5'b10000
   } state_type;

   // configuration registers
   logic [mbf_pkg::RADIUS_W-1:0] cfg_radius_ff, cfg_radius_in;
   logic [mbf_pkg::WIDTH_W-1:0]  cfg_width_ff, cfg_width_in;
   logic [HW-1:0]                cfg_height_ff, cfg_height_in;
   logic [1:0]                   cfg_hold_ff;
   logic                         restart;

   // effective settings registered from the config registers, and the settings derived from them
   logic [RW-1:0]     r_eff, r_ff;
   logic [WW-1:0]     w_eff, w_ff;
   logic [HW-1:0]     h_eff, h_ff;
   logic [LAG_W-1:0]  lag_ff, lag_in;
   logic [PTR_W-1:0]  span_ff;
   logic [PTR_W-1:0]  rowstep_ff, rowstep_in;
   logic [TAG_W-1:0]  twor_ff, twor_in;
   logic [AREA_W-1:0] area_ff;
   logic [RW:0]       side;

   // stream position
   state_type                 state_ff, state_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [mbf_pkg::ROW_W-1:0] row_ff, row_in;
   logic [LAG_W-1:0]          cnt_ff, cnt_in;
   logic [PTR_W-1:0]          wptr_ff, wptr_in;
   logic [COL_W-1:0]          ocol_ff, ocol_in;
   logic [HW-1:0]             orow_ff, orow_in;

   // window scan
   logic [PTR_W-1:0]          raddr_ff, raddr_in;
   logic [TAG_W-1:0]          dy_ff, dy_in, dx_ff, dx_in;
   logic [mbf_pkg::ROW_W-1:0] rowoff_ff, rowoff_in;
   logic [CO_W-1:0]           coloff_ff, coloff_in;
   logic [CO_W-1:0]           ox_ff, ox_in;
   logic                      last_pend_ff, last_pend_in;
   logic                      iss_v_ff, iss_v_in;
   logic [TAG_W-1:0]          iss_tag_ff;
   logic                      iss_in_ff, inwin;
   logic                      chain_clear;

   // drain and divide
   logic [CNT_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] dsh_ff, dsh_in;
   logic [QW-1:0]    quot_ff, quot_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] mean_ff, mean_in;
   logic          flast_ff, flast_in;

   logic          accept;
   logic [PW-1:0] store_wdata, store_rdata;
   logic          frame_end;
   logic [PTR_W:0] sum_a, sum_b;

   // chain wiring
   logic             ch_valid  [NC+1];
   logic [TAG_W-1:0] ch_tag    [NC+1];
   logic [PW-1:0]    ch_sample [NC+1];
   logic [SUM_W-1:0] ch_pass   [NC+1];

   // ---------------- configuration ----------------
   always_comb begin
      cfg_radius_in = cfg_radius_ff;
      cfg_width_in  = cfg_width_ff;
      cfg_height_in = cfg_height_ff;
      restart       = 1'b0;
      if (csr_we) begin
         unique case (mbf_pkg::csr_index_type'(csr_index))
            mbf_pkg::CSR_RADIUS: begin
               cfg_radius_in = csr_wdata[mbf_pkg::RADIUS_W-1:0];
               restart       = 1'b1;
            end
            mbf_pkg::CSR_WIDTH: begin
               cfg_width_in = csr_wdata[mbf_pkg::WIDTH_W-1:0];
               restart      = 1'b1;
            end
            mbf_pkg::CSR_HEIGHT: begin
               cfg_height_in = csr_wdata[HW-1:0];
               restart       = 1'b1;
            end
            default: begin
               restart = 1'b0;  // unlisted index writes no register and does not restart
            end
         endcase
      end
   end

   // saturate radius and width, width zero acts as one, height zero acts as one
   always_comb begin
      r_eff = (32'(cfg_radius_ff) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_radius_ff);
      if (cfg_width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(cfg_width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(cfg_width_ff);
      end
      h_eff = (cfg_height_ff == '0) ? HW'(1) : cfg_height_ff;
   end

   // derived settings: lag, store span of a window, row jump, area
   always_comb begin
      lag_in  = LAG_W'(r_ff) * LAG_W'(w_ff) + LAG_W'(r_ff);
      twor_in = TAG_W'({r_ff, 1'b0});
      side    = {r_ff, 1'b1};
      // jump from the right edge of one window row to the left edge of the next
      if (PTR_W'(w_ff) >= PTR_W'(twor_ff)) begin
         rowstep_in = PTR_W'(w_ff) - PTR_W'(twor_ff);
      end else begin
         rowstep_in = PTR_W'(DEPTH) - PTR_W'(twor_ff) + PTR_W'(w_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_radius_ff <= mbf_pkg::RADIUS_RESET;
         cfg_width_ff  <= mbf_pkg::WIDTH_RESET;
         cfg_height_ff <= mbf_pkg::HEIGHT_RESET;
         cfg_hold_ff   <= CFG_SETTLE;
      end else begin
         cfg_radius_ff <= cfg_radius_in;
         cfg_width_ff  <= cfg_width_in;
         cfg_height_ff <= cfg_height_in;
         // a register write reloads the hold count while the settings below settle
         if (csr_we) begin
            cfg_hold_ff <= CFG_SETTLE;
         end else if (cfg_hold_ff != '0) begin
            cfg_hold_ff <= cfg_hold_ff - 1'b1;
         end
      end
      r_ff       <= r_eff;
      w_ff       <= w_eff;
      h_ff       <= h_eff;
      lag_ff     <= lag_in;
      span_ff    <= PTR_W'({lag_ff, 1'b0});
      twor_ff    <= twor_in;
      rowstep_ff <= rowstep_in;
      area_ff    <= AREA_W'(side) * AREA_W'(side);
   end

   // ---------------- line store ----------------
   assign accept = req_ch.valid && req_ch.ready;

   // flush items and pixels past the last row are stored as zero
   assign store_wdata = (row_ff < mbf_pkg::ROW_W'(h_ff) && req_ch.cmd == mbf_pkg::CMD_PIXEL)
                        ? req_ch.pixel : '0;

   mbf_ram #(
      .WIDTH (PW),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock (clock),
      .we    (accept),
      .waddr (wptr_ff),
      .wdata (store_wdata),
      .raddr (raddr_ff),
      .rdata (store_rdata)
   );

   // window position of the current read lies inside the image
   assign inwin = (rowoff_ff >= mbf_pkg::ROW_W'(r_ff))
               && (rowoff_ff < mbf_pkg::ROW_W'(h_ff) + mbf_pkg::ROW_W'(r_ff))
               && (coloff_ff >= CO_W'(r_ff))
               && (coloff_ff < CO_W'(w_ff) + CO_W'(r_ff));

   assign frame_end = (orow_ff == h_ff - 1'b1)
                   && ({1'b0, ocol_ff} == (COL_W+1)'(w_ff) - 1'b1);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cnt_in       = cnt_ff;
      wptr_in      = wptr_ff;
      ocol_in      = ocol_ff;
      orow_in      = orow_ff;
      raddr_in     = raddr_ff;
      dy_in        = dy_ff;
      dx_in        = dx_ff;
      rowoff_in    = rowoff_ff;
      coloff_in    = coloff_ff;
      ox_in        = ox_ff;
      last_pend_in = last_pend_ff;
      iss_v_in     = 1'b0;
      chain_clear  = 1'b0;
      step_in      = step_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quot_in      = quot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      mean_in      = mean_ff;
      flast_in     = flast_ff;
      sum_a        = '0;
      sum_b        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // advance the input raster position
               if ({1'b0, col_ff} + 1'b1 >= (COL_W+1)'(w_ff)) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
               if (cnt_ff == lag_ff) begin
                  // this item completes a window: start the scan at its top left
                  if (wptr_ff >= span_ff) begin
                     raddr_in = wptr_ff - span_ff;
                  end else begin
                     raddr_in = wptr_ff + (PTR_W'(DEPTH) - span_ff);
                  end
                  dy_in        = '0;
                  dx_in        = '0;
                  rowoff_in    = mbf_pkg::ROW_W'(orow_ff);
                  coloff_in    = CO_W'(ocol_ff);
                  ox_in        = CO_W'(ocol_ff);
                  last_pend_in = frame_end;
                  chain_clear  = 1'b1;
                  state_in     = ST_SCAN;
                  if ({1'b0, ocol_ff} + 1'b1 >= (COL_W+1)'(w_ff)) begin
                     ocol_in = '0;
                     orow_in = orow_ff + 1'b1;
                  end else begin
                     ocol_in = ocol_ff + 1'b1;
                  end
                  if (frame_end) begin
                     // frame done: next item starts a new frame
                     col_in  = '0;
                     row_in  = '0;
                     cnt_in  = '0;
                     wptr_in = '0;
                     ocol_in = '0;
                     orow_in = '0;
                  end
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // one store read per cycle, row by row across the window
            iss_v_in = 1'b1;
            if (dx_ff == twor_ff) begin
               dx_in     = '0;
               coloff_in = ox_ff;
               dy_in     = dy_ff + 1'b1;
               rowoff_in = rowoff_ff + 1'b1;
               sum_a     = {1'b0, raddr_ff} + {1'b0, rowstep_ff};
               if (dy_ff == twor_ff) begin
                  state_in = ST_DRAIN;
                  step_in  = CNT_W'(DRAIN_CYC);
               end
            end else begin
               dx_in     = dx_ff + 1'b1;
               coloff_in = coloff_ff + 1'b1;
               sum_a     = {1'b0, raddr_ff} + 1'b1;
            end
            sum_b    = sum_a - (PTR_W+1)'(DEPTH);
            raddr_in = (sum_a >= (PTR_W+1)'(DEPTH)) ? sum_b[PTR_W-1:0] : sum_a[PTR_W-1:0];
         end
         ST_DRAIN: begin
            // let the last samples reach their cells and the prefix sums settle
            if (step_ff == '0) begin
               rem_in   = ch_pass[NC];
               dsh_in   = SUM_W'(area_ff) << (QW - 1);
               quot_in  = '0;
               step_in  = CNT_W'(QW);
               state_in = ST_DIVIDE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_DIVIDE: begin
            // restoring division, one quotient bit per cycle; the sum is below 256 areas
            if (rem_ff >= dsh_ff) begin
               rem_in  = rem_ff - dsh_ff;
               quot_in = {quot_ff[QW-2:0], 1'b1};
            end else begin
               quot_in = {quot_ff[QW-2:0], 1'b0};
            end
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == CNT_W'(1)) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            // quotient fits eight bits, so it is passed on without a clamp
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               mean_in      = quot_ff;
               flast_in     = last_pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a write to any listed register restarts the frame
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         cnt_in  = '0;
         wptr_in = '0;
         ocol_in = '0;
         orow_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         wptr_ff      <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         iss_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         wptr_ff      <= wptr_in;
         ocol_ff      <= ocol_in;
         orow_ff      <= orow_in;
         iss_v_ff     <= iss_v_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
      raddr_ff     <= raddr_in;
      dy_ff        <= dy_in;
      dx_ff        <= dx_in;
      rowoff_ff    <= rowoff_in;
      coloff_ff    <= coloff_in;
      ox_ff        <= ox_in;
      last_pend_ff <= last_pend_in;
      iss_tag_ff   <= dy_ff;
      iss_in_ff    <= inwin;
      rem_ff       <= rem_in;
      dsh_ff       <= dsh_in;
      quot_ff      <= quot_in;
      mean_ff      <= mean_in;
      flast_ff     <= flast_in;
   end

   assign req_ch.ready = (state_ff == ST_IDLE) && (cfg_hold_ff == '0);

   // ---------------- row cell chain ----------------
   // store data lines up with the issue registers; positions off the image enter as zero
   assign ch_valid[0]  = iss_v_ff;
   assign ch_tag[0]    = iss_tag_ff;
   assign ch_sample[0] = iss_in_ff ? store_rdata : '0;
   assign ch_pass[0]   = '0;

   for (genvar gi = 0; gi < NC; gi++) begin : g_cell
      mbf_cell #(
         .SAMPLE_W (PW),
         .TAG_W    (TAG_W),
         .ACC_W    (ACC_W),
         .SUM_W    (SUM_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .clear      (chain_clear),
         .in_valid   (ch_valid[gi]),
         .in_tag     (ch_tag[gi]),
         .in_sample  (ch_sample[gi]),
         .in_pass    (ch_pass[gi]),
         .out_valid  (ch_valid[gi+1]),
         .out_tag    (ch_tag[gi+1]),
         .out_sample (ch_sample[gi+1]),
         .out_pass   (ch_pass[gi+1])
      );
   end

   // ---------------- result channel ----------------
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.mean_value = mean_ff;
   assign rsp_ch.frame_last = flast_ff;
endmodule
`default_nettype wire

>>> sv/mbf_checker.sv
// port level checks for the box mean filter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module mbf_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [mbf_pkg::PIXEL_W-1:0]     rsp_mean_value,
   input wire logic                            rsp_frame_last,
   input wire logic                            csr_we
);
   // a result stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_mean_value) && $stable(rsp_frame_last))
      else $error("result payload changed while stalled");

   // no item is taken right after a register write
   a_cfg_settle: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("item taken before settings settled");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");
endmodule

bind box_mean_filter_unit mbf_checker u_mbf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_mean_value (rsp_ch.mean_value),
   .rsp_frame_last (rsp_ch.frame_last),
   .csr_we         (csr_we)
);
`default_nettype wire
